// ----- rtl/frame_counter_extend_and_offset_assert.svh -----
// Assertion macros used by the frame counter pipeline module.
`ifndef FRAME_COUNTER_EXTEND_AND_OFFSET_ASSERT_SVH
`define FRAME_COUNTER_EXTEND_AND_OFFSET_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define FCEO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FCEO_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCEO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fceo_pkg.sv -----
// Types and constants shared by the frame counter extension modules.
package fceo_pkg;

    localparam int HEAD_W = 2;
    localparam int CNT_W  = 32;
    localparam int EXT_W  = 64;
    localparam int LIM_W  = 16;

    localparam logic [LIM_W-1:0] LIMIT_RST = 16'd1000;
    localparam logic [CNT_W-1:0] WRAP_LO   = 32'h8000_0000;
    localparam logic [CNT_W-1:0] WRAP_HI   = 32'hC000_0000;

    typedef struct packed {
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] last;
        logic [CNT_W-1:0] wraps;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic              resync;
        logic [HEAD_W-1:0] head;
    } t_stage_ctl;

endpackage

// ----- rtl/fceo_mem.sv -----
// Per-head counter state memory with registered read and write-through bypass.
module fceo_mem #(
    parameter int DEPTH = 4,
    parameter int IDX_W = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output fceo_pkg::t_entry     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  fceo_pkg::t_entry     i_wr_data
);

    fceo_pkg::t_entry r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    fceo_pkg::t_entry r_q;
    fceo_pkg::t_entry r_byp_data;
    logic             r_q_vld;
    logic             r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_idx];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_idx];
                r_byp   <= i_wr_en && (i_wr_idx == i_rd_idx);
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_q_vld ? r_q : '0);

endmodule

// ----- rtl/fceo_pipe.sv -----
// Two-stage read-modify-write pipeline: count extension, then offset resync.
`include "frame_counter_extend_and_offset_assert.svh"

module fceo_pipe #(
    parameter int NUM_HEADS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic                              i_req,
    input  logic [fceo_pkg::HEAD_W-1:0]       i_head,
    input  logic [fceo_pkg::CNT_W-1:0]        i_hw,
    input  logic [fceo_pkg::EXT_W-1:0]        i_expect,
    input  logic                              i_ok,
    input  logic [fceo_pkg::LIM_W-1:0]        i_limit,
    input  logic                              i_take,
    output fceo_pkg::t_stage_ctl              o_p1,
    output fceo_pkg::t_stage_ctl              o_p2,
    output logic [fceo_pkg::EXT_W-1:0]        o_ext,
    output logic [fceo_pkg::CNT_W-1:0]        o_target
);

    localparam int IDX_W = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;

    logic                             in_hok;
    logic [IDX_W-1:0]                 in_idx;

    logic                             r_p1_valid;
    logic                             r_p1_req;
    logic                             r_p1_ok;
    logic                             r_p1_hok;
    logic [IDX_W-1:0]                 r_p1_idx;
    logic [fceo_pkg::HEAD_W-1:0]      r_p1_head;
    logic [fceo_pkg::CNT_W-1:0]       r_p1_hw;
    logic [fceo_pkg::EXT_W-1:0]       r_p1_exp;

    logic                             r_p2_valid;
    logic                             r_p2_wr;
    logic                             r_p2_resync;
    logic                             r_p2_tgt_en;
    logic [IDX_W-1:0]                 r_p2_idx;
    logic [fceo_pkg::HEAD_W-1:0]      r_p2_head;
    fceo_pkg::t_entry                 r_p2_ent;
    logic [fceo_pkg::EXT_W-1:0]       r_p2_ext;
    logic [fceo_pkg::EXT_W-1:0]       r_p2_diff;
    logic [fceo_pkg::CNT_W-1:0]       r_p2_exp_lo;

    fceo_pkg::t_entry                 mem_rd;
    fceo_pkg::t_entry                 fwd;
    fceo_pkg::t_entry                 n_ent;
    fceo_pkg::t_entry                 wr_data;
    logic                             wr_en;
    logic                             p2_free;
    logic                             p1_adv;
    logic                             do_ext;
    logic [fceo_pkg::CNT_W-1:0]       v;
    logic [fceo_pkg::CNT_W-1:0]       d;
    logic                             bump;
    logic [fceo_pkg::CNT_W-1:0]       wraps_n;
    logic [fceo_pkg::EXT_W-1:0]       ext_full;
    logic [fceo_pkg::EXT_W-1:0]       n_diff;

    logic [fceo_pkg::CNT_W-1:0]       lim32;
    logic [fceo_pkg::EXT_W-1:0]       lim64;
    logic                             exceed;
    logic                             below;
    logic [fceo_pkg::CNT_W-1:0]       off_add;
    logic [fceo_pkg::CNT_W-1:0]       off_fin;

    assign in_hok  = int'(i_head) < NUM_HEADS;
    assign in_idx  = IDX_W'(i_head);
    assign p2_free = !r_p2_valid || i_take;
    assign p1_adv  = r_p1_valid && p2_free;

    fceo_mem #(
        .DEPTH (NUM_HEADS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (i_acc),
        .i_rd_idx  (in_idx),
        .o_rd_data (mem_rd),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_p2_idx),
        .i_wr_data (wr_data)
    );

    // stage 1: extend the hardware count
    always_comb begin
        fwd      = (r_p2_valid && r_p2_wr && (r_p2_idx == r_p1_idx)) ? r_p2_ent : mem_rd;
        do_ext   = r_p1_hok && (!r_p1_req || r_p1_ok);
        v        = r_p1_hw + fwd.offset;
        d        = v - fwd.last;
        bump     = (d >= fceo_pkg::WRAP_LO) && (d < fceo_pkg::WRAP_HI);
        wraps_n  = fwd.wraps + fceo_pkg::CNT_W'(bump);
        ext_full = {wraps_n, v};
        n_diff   = r_p1_exp - ext_full;
        n_ent    = fwd;
        if (do_ext) begin
            n_ent.last  = v;
            n_ent.wraps = wraps_n;
        end
    end

    // stage 2: resync the offset and form the hardware target
    always_comb begin
        lim32   = fceo_pkg::CNT_W'(i_limit);
        lim64   = fceo_pkg::EXT_W'(i_limit);
        exceed  = r_p2_diff[fceo_pkg::EXT_W-1]
                ? ((i_limit == '0) || (r_p2_diff < ('0 - lim64)))
                : (r_p2_diff > lim64);
        off_add = r_p2_ent.offset + r_p2_diff[fceo_pkg::CNT_W-1:0];
        below   = off_add[fceo_pkg::CNT_W-1]
                ? ((i_limit != '0) && (off_add > ('0 - lim32)))
                : (off_add < lim32);
        off_fin = r_p2_ent.offset;
        if (r_p2_resync && exceed) begin
            off_fin = below ? '0 : off_add;
        end
        wr_data        = r_p2_ent;
        wr_data.offset = off_fin;
        wr_en          = i_take && r_p2_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            if (i_acc) begin
                r_p1_valid <= 1'b1;
            end else if (p1_adv) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_adv) begin
                r_p2_valid <= 1'b1;
            end else if (i_take) begin
                r_p2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_p1_req  <= i_req;
            r_p1_ok   <= i_ok;
            r_p1_hok  <= in_hok;
            r_p1_idx  <= in_idx;
            r_p1_head <= i_head;
            r_p1_hw   <= i_hw;
            r_p1_exp  <= i_expect;
        end
        if (p1_adv) begin
            r_p2_wr     <= do_ext;
            r_p2_resync <= r_p1_hok && r_p1_req && r_p1_ok;
            r_p2_tgt_en <= r_p1_hok && r_p1_req;
            r_p2_idx    <= r_p1_idx;
            r_p2_head   <= r_p1_head;
            r_p2_ent    <= n_ent;
            r_p2_ext    <= do_ext ? ext_full : '0;
            r_p2_diff   <= n_diff;
            r_p2_exp_lo <= r_p1_exp[fceo_pkg::CNT_W-1:0];
        end
    end

    assign o_p1.valid  = r_p1_valid;
    assign o_p1.resync = r_p1_hok && r_p1_req && r_p1_ok;
    assign o_p1.head   = r_p1_head;
    assign o_p2.valid  = r_p2_valid;
    assign o_p2.resync = r_p2_resync;
    assign o_p2.head   = r_p2_head;
    assign o_ext       = r_p2_ext;
    assign o_target    = r_p2_tgt_en ? (r_p2_exp_lo - off_fin) : '0;

    `FCEO_ASSERT(a_no_resync_overlap, i_clk, i_rst_n, !(r_p1_valid && r_p2_valid && r_p2_resync && (r_p1_head == r_p2_head)), "resync item overlaps a later item of the same head")
    `FCEO_ASSERT_SAME(a_ext_zero, i_clk, i_rst_n, r_p2_valid && !r_p2_wr, r_p2_ext == '0, "extended count not zero for a skipped conversion")
    `FCEO_ASSERT_SAME(a_ext_entry, i_clk, i_rst_n, r_p2_valid && r_p2_wr, (r_p2_ext[63:32] == r_p2_ent.wraps) && (r_p2_ext[31:0] == r_p2_ent.last), "extended count differs from stored state")
    `FCEO_ASSERT_NEXT(a_p2_fill, i_clk, i_rst_n, r_p1_valid && !r_p2_valid, r_p2_valid, "stage 1 item did not advance into an empty stage 2")

endmodule

// ----- rtl/frame_counter_extend_and_offset.sv -----
// Top level: stream handshake, interlock, limit register and result register.
//
//  channel   dir  tdata (low bit up)                     tuser (low bit up)
//  s_axis    in   hw_count[31:0], expect_count[95:32]    req_type[0], head[2:1], query_ok[3]
//  m_axis    out  ext_count[63:0], hw_target[95:64]      -
//  cfg       in   resync_limit[15:0] on i_cfg_we         -
//
//  An input transfer passes the state read with extend, the resync stage and the result register before result valid.
//  One item per cycle while the result does not stall; a request 1 with query_ok set holds off a
//  following item of the same head until its offset is written back, longer while the result stalls.
//  Synchronous active-low reset clears all head state (valid bits) and sets the limit to 1000.
//  A stalled result register holds; the pipeline keeps filling until every stage is full.
module frame_counter_extend_and_offset #(
    parameter int NUM_HEADS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // hw_count, expect_count
    input  logic [3:0]   i_s_axis_tuser,   // req_type, head, query_ok
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // ext_count, hw_target
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    logic [fceo_pkg::LIM_W-1:0]  r_limit;
    logic                        r_out_valid;
    logic [fceo_pkg::EXT_W-1:0]  r_out_ext;
    logic [fceo_pkg::CNT_W-1:0]  r_out_tgt;

    fceo_pkg::t_stage_ctl        p1;
    fceo_pkg::t_stage_ctl        p2;
    logic [fceo_pkg::EXT_W-1:0]  p2_ext;
    logic [fceo_pkg::CNT_W-1:0]  p2_tgt;
    logic [fceo_pkg::HEAD_W-1:0] in_head;
    logic                        take;
    logic                        p2_free;
    logic                        p1_free;
    logic                        hazard;
    logic                        acc;

    assign in_head = i_s_axis_tuser[2:1];
    assign take    = p2.valid && (!r_out_valid || i_m_axis_tready);
    assign p2_free = !p2.valid || take;
    assign p1_free = !p1.valid || p2_free;
    assign hazard  = (p1.valid && p1.resync && (p1.head == in_head))
                  || (p2.valid && p2.resync && (p2.head == in_head) && !take);
    assign o_s_axis_tready = p1_free && !hazard;
    assign acc     = i_s_axis_tvalid && o_s_axis_tready;

    fceo_pipe #(
        .NUM_HEADS (NUM_HEADS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_req    (i_s_axis_tuser[0]),
        .i_head   (in_head),
        .i_hw     (i_s_axis_tdata[31:0]),
        .i_expect (i_s_axis_tdata[95:32]),
        .i_ok     (i_s_axis_tuser[3]),
        .i_limit  (r_limit),
        .i_take   (take),
        .o_p1     (p1),
        .o_p2     (p2),
        .o_ext    (p2_ext),
        .o_target (p2_tgt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= fceo_pkg::LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_ext <= p2_ext;
            r_out_tgt <= p2_tgt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_tgt, r_out_ext};

endmodule

// ----- tb/tb_frame_counter_extend_and_offset.sv -----
// Self-checking testbench for the frame counter extension and offset block.
module tb_frame_counter_extend_and_offset;

    localparam int          NUM_HEADS  = 4;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned MAX_REPORT = 10;

    typedef enum bit {
        REQ_EXTEND = 1'b0,
        REQ_TO_HW  = 1'b1
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        bit [1:0]    head;
        bit [31:0]   hw_count;
        bit [63:0]   expect_count;
        bit          query_ok;
        int unsigned gap;
        bit          drain;
    } t_frame_req;

    typedef struct {
        bit [63:0] ext_count;
        bit [31:0] hw_target;
    } t_frame_counts;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;   // hw_count, expect_count
    logic [3:0]  i_s_axis_tuser = '0;   // req_type, head, query_ok
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [95:0] o_m_axis_tdata;        // ext_count, hw_target
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    t_frame_req    pending_reqs[$];
    t_frame_counts want_counts[$];

    bit [31:0] head_offs [NUM_HEADS];
    bit [31:0] head_last [NUM_HEADS];
    bit [31:0] head_wraps[NUM_HEADS];
    bit [15:0] resync_lim;

    bit [31:0] gen_hw  [NUM_HEADS];
    bit [31:0] gen_wrap[NUM_HEADS];
    bit        no_gap_run;

    t_frame_req  cur_req;
    bit          loaded;
    bit          in_fire;
    int unsigned gap_left;
    int unsigned stall_left;
    bit          no_stall_run;
    int unsigned fail_cnt;
    int unsigned idle_cycles;

    frame_counter_extend_and_offset #(
        .NUM_HEADS(NUM_HEADS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit [63:0] extend_hw(int unsigned h, bit [31:0] hw);
        bit [31:0] v;
        bit [31:0] d;
        v = hw + head_offs[h];
        d = v - head_last[h];
        if (d >= fceo_pkg::WRAP_LO && d < fceo_pkg::WRAP_HI) begin
            head_wraps[h] = head_wraps[h] + 32'd1;
        end
        head_last[h] = v;
        return {head_wraps[h], v};
    endfunction

    function automatic t_frame_counts predict_counts(t_frame_req r);
        t_frame_counts res;
        int unsigned   h;
        bit [63:0]     diff;
        bit [63:0]     mag64;
        bit [31:0]     mag32;
        res.ext_count = '0;
        res.hw_target = '0;
        h = r.head;
        if (h < NUM_HEADS) begin
            if (r.kind == REQ_EXTEND) begin
                res.ext_count = extend_hw(h, r.hw_count);
            end else begin
                if (r.query_ok) begin
                    res.ext_count = extend_hw(h, r.hw_count);
                    diff = r.expect_count - res.ext_count;
                    mag64 = diff[63] ? (64'd0 - diff) : diff;
                    if (mag64 > {48'd0, resync_lim}) begin
                        head_offs[h] = head_offs[h] + diff[31:0];
                        mag32 = head_offs[h][31] ? (32'd0 - head_offs[h]) : head_offs[h];
                        if (mag32 < {16'd0, resync_lim}) begin
                            head_offs[h] = '0;
                        end
                    end
                end
                res.hw_target = r.expect_count[31:0] - head_offs[h];
            end
        end
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 19) == 0) begin
            no_gap_run = !no_gap_run;
        end
        return no_gap_run ? 0 : $urandom_range(0, 9);
    endfunction

    // sender: hold the current transfer until accepted, then wait out the next gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            loaded = 1'b0;
            gap_left = 0;
        end else begin
            in_fire = i_s_axis_tvalid && o_s_axis_tready;
            if (in_fire) begin
                want_counts.push_back(predict_counts(cur_req));
                loaded = 1'b0;
            end
            if (!loaded && pending_reqs.size() != 0) begin
                cur_req = pending_reqs.pop_front();
                gap_left = cur_req.gap;
                loaded = 1'b1;
            end
            if (i_s_axis_tvalid && !in_fire) begin
                i_s_axis_tvalid <= 1'b1;
            end else if (loaded && gap_left > 0) begin
                gap_left = gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (loaded && !(cur_req.drain && want_counts.size() != 0)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {cur_req.expect_count, cur_req.hw_count};
                i_s_axis_tuser  <= {cur_req.query_ok, cur_req.head, cur_req.kind};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each result against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        t_frame_counts want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (want_counts.size() == 0) begin
                    if (fail_cnt < MAX_REPORT) begin
                        $display("unexpected result ext=%h target=%h",
                                 o_m_axis_tdata[63:0], o_m_axis_tdata[95:64]);
                    end
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = want_counts.pop_front();
                    if (o_m_axis_tdata[63:0] !== want.ext_count ||
                        o_m_axis_tdata[95:64] !== want.hw_target) begin
                        if (fail_cnt < MAX_REPORT) begin
                            $display("mismatch ext exp=%h got=%h  target exp=%h got=%h",
                                     want.ext_count, o_m_axis_tdata[63:0],
                                     want.hw_target, o_m_axis_tdata[95:64]);
                        end
                        fail_cnt = fail_cnt + 1;
                    end
                end
                if ($urandom_range(0, 19) == 0) begin
                    no_stall_run = !no_stall_run;
                end
                stall_left = no_stall_run ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(t_req_kind k, bit [1:0] h, bit [31:0] hw, bit [63:0] ec,
                            bit ok, int unsigned gap, bit drain);
        t_frame_req r;
        r.kind = k;
        r.head = h;
        r.hw_count = hw;
        r.expect_count = ec;
        r.query_ok = ok;
        r.gap = gap;
        r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_reqs.size() != 0 || loaded || i_s_axis_tvalid ||
                   want_counts.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(bit [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        resync_lim = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed counter streams per head, with drops, jumps and noise
    task automatic push_random(int unsigned n);
        int unsigned h;
        int unsigned sel;
        int unsigned w;
        bit [31:0]   prev;
        bit [31:0]   step;
        bit [63:0]   ec;
        longint      delta;
        t_req_kind   k;
        bit          ok;
        repeat (n) begin
            h = $urandom_range(0, NUM_HEADS - 1);
            sel = $urandom_range(0, 99);
            prev = gen_hw[h];
            if (sel < 3) begin
                gen_hw[h] = $urandom();
            end else if (sel < 6) begin
                gen_hw[h] = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            end else if (sel < 11) begin
                gen_hw[h] = prev - (32'h4000_0000 + $urandom_range(0, 32'h4000_0000));
            end else begin
                gen_hw[h] = prev + $urandom_range(0, 3);
            end
            step = gen_hw[h] - prev;
            if (step >= fceo_pkg::WRAP_LO && step < fceo_pkg::WRAP_HI) begin
                gen_wrap[h] = gen_wrap[h] + 32'd1;
            end
            k = $urandom_range(0, 1) ? REQ_TO_HW : REQ_EXTEND;
            ok = $urandom_range(0, 9) != 0;
            sel = $urandom_range(0, 9);
            if (k == REQ_EXTEND || sel == 9) begin
                ec = {$urandom(), $urandom()};
            end else begin
                w = (sel < 5) ? resync_lim + 1 : 4 * resync_lim + 8;
                delta = longint'($urandom_range(0, 2 * w)) - longint'(w);
                ec = {gen_wrap[h], gen_hw[h]} + 64'(delta);
            end
            push_req(k, h[1:0], gen_hw[h], ec, ok, draw_gap(), $urandom_range(0, 59) == 0);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_HEADS; i++) begin
            head_offs[i]  = '0;
            head_last[i]  = '0;
            head_wraps[i] = '0;
            gen_hw[i]     = (i % 2) ? 32'hFFFF_FF00 : 32'd0;
            gen_wrap[i]   = '0;
        end
        resync_lim = fceo_pkg::LIMIT_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_req(REQ_EXTEND, 2'd0, 32'h0000_0000, 64'd0, 1'b0, draw_gap(), 1'b0);
        push_req(REQ_EXTEND, 2'd0, 32'hBFFF_FFFF, 64'd0, 1'b0, draw_gap(), 1'b0);
        push_req(REQ_EXTEND, 2'd1, 32'hC000_0000, 64'd0, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_EXTEND, 2'd2, 32'h8000_0000, 64'd0, 1'b0, draw_gap(), 1'b0);
        push_req(REQ_EXTEND, 2'd2, 32'hFFFF_FFFF, '1, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd3, 32'd100, 64'd1100, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd3, 32'd101, 64'd1102, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd3, 32'd102, 64'd603, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd3, 32'hFFFF_FFFF, '1, 1'b0, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd0, 32'hFFFF_FFFF, '1, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd1, 32'h0000_0000, 64'h8000_0000_0000_0000, 1'b1,
                 draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd2, 32'hFFFF_FFFF, 64'd0, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_EXTEND, 2'd0, 32'hFFFF_FFFF, '1, 1'b1, draw_gap(), 1'b0);
        push_req(REQ_TO_HW, 2'd1, 32'd5, 64'd5000, 1'b1, 0, 1'b1);
        push_req(REQ_TO_HW, 2'd1, 32'd6, 64'd9000, 1'b1, 0, 1'b0);
        push_req(REQ_TO_HW, 2'd1, 32'd7, 64'd20, 1'b1, 0, 1'b0);
        push_req(REQ_EXTEND, 2'd1, 32'd8, 64'd0, 1'b0, 0, 1'b0);
        push_req(REQ_TO_HW, 2'd0, 32'd3, 64'd3, 1'b0, draw_gap(), 1'b0);
        push_random(250);
        wait_idle();

        write_limit(16'd0);
        push_random(150);
        wait_idle();

        write_limit(16'd1);
        push_random(150);
        wait_idle();

        write_limit(16'hFFFF);
        push_random(200);
        wait_idle();

        write_limit(16'($urandom_range(2, 16'hFFFE)));
        push_random(200);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0 && want_counts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
